>>> hw/rtl/emgf_pkg.sv
package emgf_pkg;

    // Channel grouping
    localparam int GROUP_A_CHANNELS = 4;
    localparam int GROUP_B_CHANNELS = 4;
    localparam int IMU_CHANNELS     = 6;
    localparam int TOTAL_CHANNELS   = GROUP_A_CHANNELS + GROUP_B_CHANNELS + IMU_CHANNELS;
    localparam int CH_GROUP_B_BASE  = GROUP_A_CHANNELS;
    localparam int CH_IMU_BASE      = GROUP_A_CHANNELS + GROUP_B_CHANNELS;
    localparam int CH_ROW_END       = TOTAL_CHANNELS - 1;

    // Window length
    localparam int ADC_RATE_HZ       = 2048;
    localparam int WINDOW_MS         = 150;
    localparam int MAX_WINDOW_ROWS   = 4096;
    localparam int CFG_W             = 13;
    localparam int ROWS_W            = $clog2(MAX_WINDOW_ROWS + 1);
    localparam int ROWCNT_W          = (MAX_WINDOW_ROWS > 1) ? $clog2(MAX_WINDOW_ROWS) : 1;
    localparam logic [CFG_W-1:0] WINDOW_ROWS_RESET =
        CFG_W'((ADC_RATE_HZ * WINDOW_MS) / 1000);

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int CH_W     = 4;
    localparam int FEAT_W   = 16;
    localparam int FIDX_W   = 3;

    // Accumulators and divider
    localparam int EMG_SUM_W   = 30;
    localparam int IMU_SUM_W   = 28;
    localparam int MAX_GROUP   = (GROUP_A_CHANNELS > GROUP_B_CHANNELS) ?
                                 GROUP_A_CHANNELS : GROUP_B_CHANNELS;
    localparam int DIVISOR_W   = $clog2(MAX_WINDOW_ROWS * MAX_GROUP + 1);
    localparam int DIVD_W      = EMG_SUM_W;
    localparam int DIVCNT_W    = $clog2(DIVD_W);
    localparam int IMU_IDX_W   = (IMU_CHANNELS > 1) ? $clog2(IMU_CHANNELS) : 1;

    // Feature indexes
    localparam logic [FIDX_W-1:0] FIDX_GROUP_A = FIDX_W'(0);
    localparam logic [FIDX_W-1:0] FIDX_GROUP_B = FIDX_W'(1);
    localparam logic [FIDX_W-1:0] FIDX_IMU_BASE = FIDX_W'(2);
    localparam logic [FIDX_W-1:0] FIDX_LAST = FIDX_W'(2 + IMU_CHANNELS - 1);

    localparam logic [FEAT_W-1:0] FEAT_MAX = {1'b0, {(FEAT_W-1){1'b1}}};
    localparam logic [FEAT_W-1:0] FEAT_MIN = {1'b1, {(FEAT_W-1){1'b0}}};

    // Window queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register map
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_ROWS = REG_IDX_W'(0);

    // Finished window totals handed from front to back
    typedef struct packed {
        logic [EMG_SUM_W-1:0]                     a_sum;
        logic [EMG_SUM_W-1:0]                     b_sum;
        logic [IMU_CHANNELS-1:0][IMU_SUM_W-1:0]   imu;
        logic [ROWS_W-1:0]                        rows;
    } snapshot_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_OUT
    } back_state_t;

endpackage

>>> hw/rtl/emgf_front.sv
module emgf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [emgf_pkg::SAMPLE_W-1:0] sample,
    input  logic [emgf_pkg::CH_W-1:0]     channel,
    input  logic [emgf_pkg::CFG_W-1:0]    window_rows,
    output logic                          q_push,
    output emgf_pkg::snapshot_t           q_wdata,
    input  logic                          q_full
);

    logic [emgf_pkg::EMG_SUM_W-1:0] a_sum_reg, a_sum_next, a_acc;
    logic [emgf_pkg::EMG_SUM_W-1:0] b_sum_reg, b_sum_next, b_acc;
    logic [emgf_pkg::IMU_CHANNELS-1:0][emgf_pkg::IMU_SUM_W-1:0] imu_reg, imu_next, imu_acc;
    logic [emgf_pkg::ROWCNT_W-1:0]  row_count_reg, row_count_next;

    logic                           accept;
    logic [emgf_pkg::SAMPLE_W-1:0]  mag;
    logic [emgf_pkg::EMG_SUM_W:0]   a_add, b_add;
    logic [emgf_pkg::IMU_SUM_W:0]   imu_add;
    logic [emgf_pkg::IMU_SUM_W:0]   sample_ext;
    logic [emgf_pkg::ROWS_W-1:0]    wr_clamp, rows;
    logic                           is_a, is_b, row_end, win_end;

    // Stall whenever the window queue is full
    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    assign mag        = sample[emgf_pkg::SAMPLE_W-1] ? (~sample + 1'b1) : sample;
    assign sample_ext = {{(emgf_pkg::IMU_SUM_W + 1 - emgf_pkg::SAMPLE_W)
                          {sample[emgf_pkg::SAMPLE_W-1]}}, sample};

    assign is_a    = channel < emgf_pkg::CH_W'(emgf_pkg::CH_GROUP_B_BASE);
    assign is_b    = !is_a && (channel < emgf_pkg::CH_W'(emgf_pkg::CH_IMU_BASE));
    assign row_end = accept && (channel == emgf_pkg::CH_W'(emgf_pkg::CH_ROW_END));

    // Saturating EMG magnitude sums
    assign a_add = {1'b0, a_sum_reg} + (emgf_pkg::EMG_SUM_W + 1)'(mag);
    assign b_add = {1'b0, b_sum_reg} + (emgf_pkg::EMG_SUM_W + 1)'(mag);

    always_comb
    begin
        a_acc = a_sum_reg;
        b_acc = b_sum_reg;
        if (accept && is_a)
        begin
            a_acc = a_add[emgf_pkg::EMG_SUM_W] ? '1 : a_add[emgf_pkg::EMG_SUM_W-1:0];
        end
        if (accept && is_b)
        begin
            b_acc = b_add[emgf_pkg::EMG_SUM_W] ? '1 : b_add[emgf_pkg::EMG_SUM_W-1:0];
        end
    end

    // Saturating signed IMU sums, one lane per channel
    always_comb
    begin
        imu_add = '0;
        for (int i = 0; i < emgf_pkg::IMU_CHANNELS; i++)
        begin
            imu_acc[i] = imu_reg[i];
            if (accept && (channel == emgf_pkg::CH_W'(emgf_pkg::CH_IMU_BASE + i)))
            begin
                imu_add = {imu_reg[i][emgf_pkg::IMU_SUM_W-1], imu_reg[i]} + sample_ext;
                if (imu_add[emgf_pkg::IMU_SUM_W] != imu_add[emgf_pkg::IMU_SUM_W-1])
                begin
                    imu_acc[i] = imu_add[emgf_pkg::IMU_SUM_W] ?
                                 {1'b1, {(emgf_pkg::IMU_SUM_W-1){1'b0}}} :
                                 {1'b0, {(emgf_pkg::IMU_SUM_W-1){1'b1}}};
                end
                else
                begin
                    imu_acc[i] = imu_add[emgf_pkg::IMU_SUM_W-1:0];
                end
            end
        end
    end

    // Clamp the window length and detect the row that closes the window
    always_comb
    begin
        if (window_rows == '0)
        begin
            wr_clamp = emgf_pkg::ROWS_W'(1);
        end
        else if (window_rows > emgf_pkg::CFG_W'(emgf_pkg::MAX_WINDOW_ROWS))
        begin
            wr_clamp = emgf_pkg::ROWS_W'(emgf_pkg::MAX_WINDOW_ROWS);
        end
        else
        begin
            wr_clamp = emgf_pkg::ROWS_W'(window_rows);
        end
    end

    assign rows    = emgf_pkg::ROWS_W'(row_count_reg) + 1'b1;
    assign win_end = row_end && (rows >= wr_clamp);

    assign q_push        = win_end;
    assign q_wdata.a_sum = a_acc;
    assign q_wdata.b_sum = b_acc;
    assign q_wdata.imu   = imu_acc;
    assign q_wdata.rows  = rows;

    // Clear the window once its totals are queued
    always_comb
    begin
        a_sum_next     = win_end ? '0 : a_acc;
        b_sum_next     = win_end ? '0 : b_acc;
        imu_next       = win_end ? '0 : imu_acc;
        row_count_next = row_count_reg;
        if (win_end)
        begin
            row_count_next = '0;
        end
        else if (row_end)
        begin
            row_count_next = rows[emgf_pkg::ROWCNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_sum_reg     <= '0;
            b_sum_reg     <= '0;
            imu_reg       <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            a_sum_reg     <= a_sum_next;
            b_sum_reg     <= b_sum_next;
            imu_reg       <= imu_next;
            row_count_reg <= row_count_next;
        end
    end

endmodule

>>> hw/rtl/emgf_queue.sv
module emgf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  emgf_pkg::snapshot_t wdata,
    output logic                full,
    input  logic                pop,
    output logic                valid,
    output emgf_pkg::snapshot_t rdata
);

    emgf_pkg::snapshot_t mem [emgf_pkg::QUEUE_DEPTH];

    logic [emgf_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [emgf_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [emgf_pkg::QCNT_W-1:0] count_reg, count_next;

    assign full  = count_reg == emgf_pkg::QCNT_W'(emgf_pkg::QUEUE_DEPTH);
    assign valid = count_reg != '0;
    assign rdata = mem[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == emgf_pkg::QPTR_W'(emgf_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == emgf_pkg::QPTR_W'(emgf_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("window queue written while full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= emgf_pkg::QCNT_W'(emgf_pkg::QUEUE_DEPTH))
        else $error("window queue count beyond depth");

endmodule

>>> hw/rtl/emgf_back.sv
module emgf_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  emgf_pkg::snapshot_t         q_rdata,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [emgf_pkg::FEAT_W-1:0] out_value,
    output logic [emgf_pkg::FIDX_W-1:0] out_index,
    output logic                        out_last
);

    emgf_pkg::back_state_t state_reg, state_next;

    logic [emgf_pkg::FIDX_W-1:0]    feat_reg, feat_next;
    logic [emgf_pkg::DIVISOR_W-1:0] rem_reg, rem_next;
    logic [emgf_pkg::DIVD_W-1:0]    quo_reg, quo_next;
    logic [emgf_pkg::DIVISOR_W-1:0] div_reg, div_next;
    logic                           neg_reg, neg_next;
    logic [emgf_pkg::DIVCNT_W-1:0]  cnt_reg, cnt_next;
    logic                           out_valid_reg, out_valid_next;
    logic [emgf_pkg::FEAT_W-1:0]    out_value_reg, out_value_next;
    logic [emgf_pkg::FIDX_W-1:0]    out_index_reg, out_index_next;
    logic                           out_last_reg, out_last_next;

    logic [emgf_pkg::FIDX_W-1:0]    load_idx;
    logic [emgf_pkg::IMU_IDX_W-1:0] lane;
    logic [emgf_pkg::IMU_SUM_W-1:0] imu_val, imu_mag;
    logic [emgf_pkg::DIVD_W-1:0]    ld_dividend;
    logic [emgf_pkg::DIVISOR_W-1:0] ld_divisor;
    logic                           ld_neg;
    logic [emgf_pkg::DIVISOR_W:0]   shift, diff;
    logic                           ge;
    logic                           pos_big, neg_big;
    logic [emgf_pkg::FEAT_W-1:0]    sat_value;
    logic                           out_free;

    // Operands of the next feature: group sums over rows times channels,
    // IMU sums as magnitude and sign over rows
    assign load_idx = (state_reg == emgf_pkg::BK_IDLE) ? emgf_pkg::FIDX_GROUP_A :
                      feat_reg + 1'b1;
    assign lane     = emgf_pkg::IMU_IDX_W'(load_idx - emgf_pkg::FIDX_IMU_BASE);
    assign imu_val  = q_rdata.imu[lane];
    assign imu_mag  = imu_val[emgf_pkg::IMU_SUM_W-1] ? (~imu_val + 1'b1) : imu_val;

    always_comb
    begin
        priority if (load_idx == emgf_pkg::FIDX_GROUP_A)
        begin
            ld_dividend = q_rdata.a_sum;
            ld_divisor  = emgf_pkg::DIVISOR_W'(32'(q_rdata.rows) *
                                               emgf_pkg::GROUP_A_CHANNELS);
            ld_neg      = 1'b0;
        end
        else if (load_idx == emgf_pkg::FIDX_GROUP_B)
        begin
            ld_dividend = q_rdata.b_sum;
            ld_divisor  = emgf_pkg::DIVISOR_W'(32'(q_rdata.rows) *
                                               emgf_pkg::GROUP_B_CHANNELS);
            ld_neg      = 1'b0;
        end
        else
        begin
            ld_dividend = emgf_pkg::DIVD_W'(imu_mag);
            ld_divisor  = emgf_pkg::DIVISOR_W'(q_rdata.rows);
            ld_neg      = imu_val[emgf_pkg::IMU_SUM_W-1];
        end
    end

    // One restoring division step per cycle
    assign shift = {rem_reg, quo_reg[emgf_pkg::DIVD_W-1]};
    assign diff  = shift - {1'b0, div_reg};
    assign ge    = shift >= {1'b0, div_reg};

    // Saturate the quotient into the signed feature range
    assign pos_big = |quo_reg[emgf_pkg::DIVD_W-1:emgf_pkg::FEAT_W-1];
    assign neg_big = (|quo_reg[emgf_pkg::DIVD_W-1:emgf_pkg::FEAT_W]) ||
                     (quo_reg[emgf_pkg::FEAT_W-1] && (|quo_reg[emgf_pkg::FEAT_W-2:0]));

    always_comb
    begin
        if (neg_reg)
        begin
            sat_value = neg_big ? emgf_pkg::FEAT_MIN :
                        (~quo_reg[emgf_pkg::FEAT_W-1:0] + 1'b1);
        end
        else
        begin
            sat_value = pos_big ? emgf_pkg::FEAT_MAX : quo_reg[emgf_pkg::FEAT_W-1:0];
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    // Sequencer: load, divide, hand over to the output register
    always_comb
    begin
        state_next     = state_reg;
        feat_next      = feat_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_next       = div_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_value_next = out_value_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;

        unique case (state_reg)
            emgf_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    feat_next  = load_idx;
                    rem_next   = '0;
                    quo_next   = ld_dividend;
                    div_next   = ld_divisor;
                    neg_next   = ld_neg;
                    cnt_next   = emgf_pkg::DIVCNT_W'(emgf_pkg::DIVD_W - 1);
                    state_next = emgf_pkg::BK_DIV;
                end
            end
            emgf_pkg::BK_DIV:
            begin
                rem_next = ge ? diff[emgf_pkg::DIVISOR_W-1:0] :
                                shift[emgf_pkg::DIVISOR_W-1:0];
                quo_next = {quo_reg[emgf_pkg::DIVD_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = emgf_pkg::BK_OUT;
                end
            end
            emgf_pkg::BK_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = sat_value;
                    out_index_next = feat_reg;
                    out_last_next  = feat_reg == emgf_pkg::FIDX_LAST;
                    if (feat_reg == emgf_pkg::FIDX_LAST)
                    begin
                        q_pop      = 1'b1;
                        state_next = emgf_pkg::BK_IDLE;
                    end
                    else
                    begin
                        feat_next  = load_idx;
                        rem_next   = '0;
                        quo_next   = ld_dividend;
                        div_next   = ld_divisor;
                        neg_next   = ld_neg;
                        cnt_next   = emgf_pkg::DIVCNT_W'(emgf_pkg::DIVD_W - 1);
                        state_next = emgf_pkg::BK_DIV;
                    end
                end
            end
            default:
            begin
                state_next = emgf_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= emgf_pkg::BK_IDLE;
            feat_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            feat_reg      <= feat_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers hold no reset
    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        div_reg       <= div_next;
        neg_reg       <= neg_next;
        out_value_reg <= out_value_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_index = out_index_reg;
    assign out_last  = out_last_reg;

    a_pop_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_valid && state_reg == emgf_pkg::BK_OUT))
        else $error("window popped without a pending entry");

    a_last_matches_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_last_reg == (out_index_reg == emgf_pkg::FIDX_LAST)))
        else $error("last flag out of step with feature index");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == emgf_pkg::BK_DIV) |-> (div_reg != '0))
        else $error("division by zero rows");

endmodule

>>> hw/rtl/emg_imu_window_features_top.sv
// EMG / IMU windowed feature extractor.
// Input stream: one sample word per channel in row-major order; s_axis_tdata
// carries the signed sample, s_axis_tuser the channel (group A EMG, group B
// EMG, then IMU). The highest channel closes a row; channels above it are
// dropped. Every window_rows rows the block sends eight feature words on the
// output stream: group A and group B mean absolute value, then six IMU means,
// with tlast on the final one.
// Throughput: one sample word a cycle while the window queue has room. Each
// feature passes through the shared bit-serial divider (one quotient bit
// a cycle over a 30-bit dividend); two finished windows can queue, after
// which s_axis_tready drops until the divider frees a slot.
// Stalls: a low m_axis_tready holds the output word and the divider waits.
// Reset: sums and row count clear, window_rows returns to 307, queue empties.
// window_rows is written over APB at address 0; the user must write it only while the stream is idle (not enforced).
module emg_imu_window_features_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [emgf_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // Sample stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,   // [15:0] sample
    input  logic [3:0]                     s_axis_tuser,   // [3:0] channel
    // Feature stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [15:0]                    m_axis_tdata,   // [15:0] feature_value
    output logic [2:0]                     m_axis_tuser,   // [2:0] feature_index
    output logic                           m_axis_tlast
);

    logic [emgf_pkg::CFG_W-1:0]     window_rows_reg, window_rows_next;
    logic [emgf_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           cfg_write;

    logic                q_push, q_full, q_pop, q_valid;
    emgf_pkg::snapshot_t q_wdata, q_rdata;

    // Register file
    assign pready    = 1'b1;
    assign reg_idx   = paddr[emgf_pkg::PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        window_rows_next = window_rows_reg;
        if (cfg_write && (reg_idx == emgf_pkg::REG_WINDOW_ROWS))
        begin
            window_rows_next = pwdata[emgf_pkg::CFG_W-1:0];
        end
    end

    assign prdata = (reg_idx == emgf_pkg::REG_WINDOW_ROWS) ? 32'(window_rows_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_rows_reg <= emgf_pkg::WINDOW_ROWS_RESET;
        end
        else
        begin
            window_rows_reg <= window_rows_next;
        end
    end

    // Accumulate and close windows
    emgf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .sample      (s_axis_tdata),
        .channel     (s_axis_tuser),
        .window_rows (window_rows_reg),
        .q_push      (q_push),
        .q_wdata     (q_wdata),
        .q_full      (q_full)
    );

    // Hold finished window totals
    emgf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    // Divide and emit features
    emgf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (m_axis_tdata),
        .out_index (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule
